// ===== hw/rtl/ibal_pkg.sv =====
// ----------------------------------------------------------------------------
// ibal_pkg
// Shared types and constants for the indexed block allocator: the input and
// result word layouts, kinds, request and status codes and sequencer states.
// ----------------------------------------------------------------------------
package ibal_pkg;

    // Field widths fixed by the word layouts.
    localparam int ReqW   = 1;
    localparam int FidInW = 4;
    localparam int CntW   = 7;
    localparam int KindW  = 2;
    localparam int PosW   = 6;
    localparam int BlkW   = 6;

    // A file's index holds at most this many readable entries.
    localparam int MaxEntries = 64;

    // Request codes.
    localparam logic [ReqW-1:0] REQ_ALLOC = 1'b0;
    localparam logic [ReqW-1:0] REQ_LIST  = 1'b1;

    // Result kinds.
    localparam logic [KindW-1:0] KIND_REPORT  = 2'd0;
    localparam logic [KindW-1:0] KIND_ENTRY   = 2'd1;
    localparam logic [KindW-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KindW-1:0] KIND_INVALID = 2'd3;

    // Allocation status codes.
    localparam logic STATUS_FULL    = 1'b0;
    localparam logic STATUS_PARTIAL = 1'b1;

    typedef struct packed {
        logic [ReqW-1:0]   req_type;
        logic [FidInW-1:0] file_id;
        logic [CntW-1:0]   block_count;
    } t_in_word;

    typedef struct packed {
        logic [KindW-1:0] result_kind;
        logic             alloc_status;
        logic [CntW-1:0]  granted_count;
        logic [BlkW-1:0]  block_number;
        logic [PosW-1:0]  entry_position;
        logic             last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_ALLOC,
        ST_LIST,
        ST_EMIT
    } t_state;

endpackage

// ===== hw/rtl/ibal_idx_ram.sv =====
// ----------------------------------------------------------------------------
// ibal_idx_ram
// Index table storage: one write port and one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ibal_idx_ram
    import ibal_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  logic [BlkW-1:0] i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output logic [BlkW-1:0] o_rdata
);

    logic [BlkW-1:0] mem [DEPTH];
    logic [BlkW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/indexed_block_allocator_core.sv =====
// Sequence: an invalid request goes straight to the emit state; an allocate
// reads the file length, then makes one index write per cycle before its
// report; a list reads the length, then gives one entry a cycle unless stalled.
// Throughput: one request at a time; the next is taken when the sequencer is
// idle, while the last word may still wait in the output register.
// Reset (synchronous, active low) frees every block and empties every file.
// ----------------------------------------------------------------------------
// indexed_block_allocator_core
// Indexed file allocation over the disk blocks. Blocks are never freed and
// are claimed first-fit, so the used blocks always form a prefix and a
// next-free counter stands for the block-used map. A small sequencer steps
// counters and comparators through the index table memory.
// ----------------------------------------------------------------------------
module indexed_block_allocator_core
    import ibal_pkg::*;
#(
    parameter int NUM_FILES  = 16,
    parameter int NUM_BLOCKS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int FidW  = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int NfW   = $clog2(NUM_BLOCKS + 1);
    localparam int ExtW  = (NfW > CntW) ? NfW : CntW;
    localparam int IdxAw = FidW + PosW;

    // Sequencer and datapath registers.
    t_state               r_state, n_state;
    logic [FidW-1:0]      r_fid, n_fid;
    logic [ReqW-1:0]      r_req, n_req;
    logic [CntW-1:0]      r_want, n_want;
    logic [NfW-1:0]       r_next_free, n_next_free;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic [CntW-1:0]      r_target, n_target;
    logic [PosW-1:0]      r_pos, n_pos;
    logic [CntW-1:0]      r_list_len, n_list_len;
    t_out_word            r_fin, n_fin;
    logic                 r_out_valid;
    t_out_word            r_out;

    // File length store with a valid bit per file.
    logic [CntW-1:0]      len_mem [NUM_FILES];
    logic [CntW-1:0]      r_len_rd;
    logic [NUM_FILES-1:0] r_len_valid;

    logic                 accept;
    logic                 slot_free;
    logic                 out_load;
    t_out_word            out_word;
    logic [8:0]           in_fid_ext;
    logic [FidW-1:0]      in_fid;
    logic                 len_we;
    logic [CntW-1:0]      len_wdata;
    logic [CntW-1:0]      eff_len;
    logic [ExtW-1:0]      avail;
    logic [CntW-1:0]      target;
    logic [ExtW-1:0]      nf_ext;
    logic                 idx_we;
    logic [PosW-1:0]      rd_pos;
    logic [BlkW-1:0]      idx_rdata;
    logic                 list_last;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign in_fid_ext = 9'(i_in_word.file_id);
    assign in_fid     = in_fid_ext[FidW-1:0];
    assign nf_ext     = ExtW'(r_next_free);
    assign eff_len    = r_len_valid[r_fid] ? r_len_rd : '0;
    assign avail      = ExtW'(NUM_BLOCKS) - nf_ext;
    assign target     = (ExtW'(r_want) < avail) ? r_want : avail[CntW-1:0];
    assign list_last  = ((CntW'(r_pos) + 1'b1) == r_list_len);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, datapath updates and output loads.
    always_comb begin
        n_state     = r_state;
        n_fid       = r_fid;
        n_req       = r_req;
        n_want      = r_want;
        n_next_free = r_next_free;
        n_cnt       = r_cnt;
        n_target    = r_target;
        n_pos       = r_pos;
        n_list_len  = r_list_len;
        n_fin       = r_fin;
        len_we      = 1'b0;
        len_wdata   = target;
        idx_we      = 1'b0;
        rd_pos      = '0;
        out_load    = 1'b0;
        out_word    = r_fin;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_fid  = in_fid;
                    n_req  = i_in_word.req_type;
                    n_want = i_in_word.block_count;
                    n_fin  = '0;
                    n_fin.last = 1'b1;
                    if ((in_fid_ext >= 9'(NUM_FILES)) ||
                        (i_in_word.req_type == REQ_ALLOC && i_in_word.block_count == '0)) begin
                        n_fin.result_kind = KIND_INVALID;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                // Length is read; index entry 0 is being fetched for a list.
                if (r_req == REQ_ALLOC) begin
                    len_we   = 1'b1;
                    n_target = target;
                    n_cnt    = '0;
                    n_fin.result_kind   = KIND_REPORT;
                    n_fin.alloc_status  = (target != r_want) ? STATUS_PARTIAL : STATUS_FULL;
                    n_fin.granted_count = target;
                    n_state = (target == '0) ? ST_EMIT : ST_ALLOC;
                end else if (eff_len == '0) begin
                    n_fin.result_kind = KIND_EMPTY;
                    n_state = ST_EMIT;
                end else begin
                    n_list_len = (eff_len > CntW'(MaxEntries)) ? CntW'(MaxEntries) : eff_len;
                    n_pos      = '0;
                    n_state    = ST_LIST;
                end
            end
            ST_ALLOC: begin
                // Claim the next free block and record it in the index.
                idx_we      = !r_cnt[CntW-1];
                n_next_free = r_next_free + 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (n_cnt == r_target) begin
                    n_state = ST_EMIT;
                end
            end
            ST_LIST: begin
                rd_pos = r_pos;
                if (slot_free) begin
                    out_load = 1'b1;
                    out_word = '0;
                    out_word.result_kind    = KIND_ENTRY;
                    out_word.block_number   = idx_rdata;
                    out_word.entry_position = r_pos;
                    out_word.last           = list_last;
                    n_pos  = r_pos + 1'b1;
                    rd_pos = n_pos;
                    if (list_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_len_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_next_free <= n_next_free;
            if (len_we) begin
                r_len_valid[r_fid] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_fid      <= n_fid;
        r_req      <= n_req;
        r_want     <= n_want;
        r_cnt      <= n_cnt;
        r_target   <= n_target;
        r_pos      <= n_pos;
        r_list_len <= n_list_len;
        r_fin      <= n_fin;
        if (out_load) begin
            r_out <= out_word;
        end
    end

    // File length store: written once per allocate, read for every request.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[r_fid] <= len_wdata;
        end
        r_len_rd <= len_mem[in_fid];
    end

    // Index table memory.
    ibal_idx_ram #(
        .DEPTH (NUM_FILES * MaxEntries),
        .AW    (IdxAw)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr ({r_fid, r_cnt[PosW-1:0]}),
        .i_wdata (nf_ext[BlkW-1:0]),
        .i_raddr ({r_fid, rd_pos}),
        .o_rdata (idx_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
